/* hw/rtl/trie_root_prefix_truncator_core_macros.svh */
// Assertion macros shared by the trie prefix truncator modules.
`ifndef TRIE_ROOT_PREFIX_TRUNCATOR_CORE_MACROS_SVH
`define TRIE_ROOT_PREFIX_TRUNCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRPT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/trpt_pkg.sv */
// Types, constants and codes shared by the trie prefix truncator modules.
`default_nettype none

package trpt_pkg;

    localparam int MAX_NODES     = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CNT_W         = NODE_W + 1;
    localparam int CHAR_W        = 5;

    localparam logic [CHAR_W-1:0] SPACE_CODE = 5'd26;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_MATCH  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd_e;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_DROP   = 2'd1,
        MODE_PASS   = 2'd2
    } t_mode_e;

    typedef enum logic [1:0] {
        ST_INIT  = 2'd0,
        ST_IDLE  = 2'd1,
        ST_LOOK  = 2'd2,
        ST_ALLOC = 2'd3
    } t_state_e;

    typedef struct packed {
        t_cmd_e             cmd;
        logic [CHAR_W-1:0]  ch;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic               emit;
        logic [CHAR_W-1:0]  out_char;
        logic               out_last;
        logic               table_full;
    } t_out_item;

    // One row of child links, one field per letter.
    typedef logic [ALPHABET_SIZE-1:0][NODE_W-1:0] t_row;

    typedef struct packed {
        logic init_root;    // zero the root row
        logic load_item;    // capture the incoming transaction
        logic commit;       // apply the item's state updates
        logic load_out;     // load the result register
        logic alloc_write;  // zero the newly allocated node's row
    } t_ctl_cmd;

    typedef struct packed {
        logic need_alloc;
    } t_dp_status;

endpackage

`default_nettype wire

/* hw/rtl/trpt_ctrl.sv */
// Controller state machine for the trie prefix truncator.
`default_nettype none

`include "trie_root_prefix_truncator_core_macros.svh"

module trpt_ctrl
    import trpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_ctl
);

    t_state_e r_state;
    t_state_e n_state;
    logic     r_out_valid;
    logic     n_out_valid;
    logic     out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    n_state = i_status.need_alloc ? ST_ALLOC : ST_IDLE;
                end
            end
            ST_ALLOC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_INIT: begin
                o_ctl.init_root = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall      = 1'b0;
                o_ctl.load_item = i_in_valid;
            end
            ST_LOOK: begin
                if (out_free) begin
                    o_ctl.commit   = 1'b1;
                    o_ctl.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            ST_ALLOC: begin
                o_ctl.alloc_write = 1'b1;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `TRPT_ASSERT_NEXT(a_accept_starts_lookup, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, r_state == ST_LOOK,
        "accepted transaction did not start a lookup")
    `TRPT_ASSERT_SAME(a_result_slot_free, i_clk, i_rst_n,
        o_ctl.load_out, !r_out_valid || !i_out_stall,
        "result loaded over a pending transaction")
    `TRPT_ASSERT_NEXT(a_alloc_single_cycle, i_clk, i_rst_n,
        r_state == ST_ALLOC, r_state == ST_IDLE && !r_out_valid == !$past(n_out_valid),
        "node allocation did not finish in one cycle")

endmodule

`default_nettype wire

/* hw/rtl/trpt_dpath.sv */
// Datapath of the trie prefix truncator: link and end-mark memories and walk state.
`default_nettype none

`include "trie_root_prefix_truncator_core_macros.svh"

module trpt_dpath
    import trpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctl_cmd   i_ctl,
    output t_dp_status o_status,
    input  t_in_item   i_in_item,
    output t_out_item  o_out_item
);

    // Row n holds the child links of node n; end marks are kept apart so that
    // marking a node needs no read-modify-write of its row.
    t_row r_link_mem [MAX_NODES];
    logic r_end_mem  [MAX_NODES];

    t_in_item          r_item;
    t_out_item         r_out;
    t_row              r_rd_row;
    logic              r_rd_end;
    logic [NODE_W-1:0] r_ins_node;
    logic              r_ins_dropped;
    logic [NODE_W-1:0] r_match_node;
    t_mode_e           r_match_mode;
    logic [CNT_W-1:0]  r_next_free;
    logic [NODE_W-1:0] r_alloc_node;
    logic              r_alloc_end;

    t_cmd_e            cur_cmd;
    logic [NODE_W-1:0] rd_addr;
    logic              letter;
    logic [NODE_W-1:0] link;
    logic              has_room;
    logic              alloc;
    logic              full;
    logic              mark;
    logic [NODE_W-1:0] ins_node_after;
    logic              ins_drop_after;
    logic [NODE_W-1:0] n_ins_node;
    logic              n_ins_dropped;
    logic              emit;
    logic [NODE_W-1:0] n_match_node;
    t_mode_e           n_match_mode;
    t_out_item         out_c;
    t_row              parent_row;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    t_row              link_wdata;
    logic              end_we;
    logic [NODE_W-1:0] end_waddr;
    logic              end_wdata;

    // The read for a new transaction is issued at the edge that accepts it.
    assign cur_cmd = i_ctl.load_item ? i_in_item.cmd : r_item.cmd;
    assign rd_addr = (cur_cmd == CMD_MATCH) ? r_match_node : r_ins_node;

    assign letter   = (32'(r_item.ch) < ALPHABET_SIZE) && (r_item.ch != SPACE_CODE);
    assign link     = r_rd_row[r_item.ch];
    assign has_room = r_next_free < CNT_W'(MAX_NODES);

    // Dictionary insert.
    always_comb begin
        ins_node_after = r_ins_node;
        ins_drop_after = r_ins_dropped;
        alloc          = 1'b0;
        full           = 1'b0;
        if (letter && !r_ins_dropped) begin
            if (link == '0) begin
                if (has_room) begin
                    alloc          = 1'b1;
                    ins_node_after = r_next_free[NODE_W-1:0];
                end else begin
                    full           = 1'b1;
                    ins_drop_after = 1'b1;
                end
            end else begin
                ins_node_after = link;
            end
        end
        mark          = r_item.last && !ins_drop_after && (ins_node_after != '0);
        n_ins_node    = r_item.last ? '0 : ins_node_after;
        n_ins_dropped = r_item.last ? 1'b0 : ins_drop_after;
    end

    // Sentence walk. The root never carries an end mark, so its stored bit is ignored.
    always_comb begin
        emit         = 1'b1;
        n_match_node = r_match_node;
        n_match_mode = r_match_mode;
        if (r_item.ch == SPACE_CODE) begin
            n_match_node = '0;
            n_match_mode = MODE_SEARCH;
        end else begin
            case (r_match_mode)
                MODE_DROP: begin
                    emit = 1'b0;
                end
                MODE_SEARCH: begin
                    if (r_rd_end && (r_match_node != '0)) begin
                        n_match_mode = MODE_DROP;
                        emit         = 1'b0;
                    end else if (!letter || (link == '0)) begin
                        n_match_mode = MODE_PASS;
                    end else begin
                        n_match_node = link;
                    end
                end
                default: begin
                    emit = 1'b1;
                end
            endcase
        end
        if (r_item.last) begin
            n_match_node = '0;
            n_match_mode = MODE_SEARCH;
        end
    end

    always_comb begin
        out_c.emit       = (r_item.cmd == CMD_MATCH) && emit;
        out_c.out_char   = r_item.ch;
        out_c.out_last   = (r_item.cmd == CMD_MATCH) && r_item.last;
        out_c.table_full = (r_item.cmd == CMD_INSERT) && full;
    end

    assign o_status.need_alloc = (r_item.cmd == CMD_INSERT) && alloc;

    // Memory write ports.
    always_comb begin
        parent_row                = r_rd_row;
        parent_row[r_item.ch]     = r_next_free[NODE_W-1:0];
        link_we    = i_ctl.init_root || i_ctl.alloc_write
                     || (i_ctl.commit && (r_item.cmd == CMD_CLEAR))
                     || (i_ctl.commit && (r_item.cmd == CMD_INSERT) && alloc);
        link_waddr = '0;
        link_wdata = '0;
        if (i_ctl.alloc_write) begin
            link_waddr = r_alloc_node;
        end else if (i_ctl.commit && (r_item.cmd == CMD_INSERT)) begin
            link_waddr = r_ins_node;
            link_wdata = parent_row;
        end
        end_we    = i_ctl.alloc_write
                    || (i_ctl.commit && (r_item.cmd == CMD_INSERT) && mark && !alloc);
        end_waddr = i_ctl.alloc_write ? r_alloc_node : ins_node_after;
        end_wdata = i_ctl.alloc_write ? r_alloc_end : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_rd_row <= r_link_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (end_we) begin
            r_end_mem[end_waddr] <= end_wdata;
        end
        r_rd_end <= r_end_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_item) begin
            r_item <= i_in_item;
        end
        if (i_ctl.load_out) begin
            r_out <= out_c;
        end
        if (i_ctl.commit) begin
            r_alloc_node <= r_next_free[NODE_W-1:0];
            r_alloc_end  <= r_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_node    <= '0;
            r_ins_dropped <= 1'b0;
            r_match_node  <= '0;
            r_match_mode  <= MODE_SEARCH;
            r_next_free   <= CNT_W'(1);
        end else if (i_ctl.commit) begin
            case (r_item.cmd)
                CMD_INSERT: begin
                    r_ins_node    <= n_ins_node;
                    r_ins_dropped <= n_ins_dropped;
                    if (alloc) begin
                        r_next_free <= r_next_free + CNT_W'(1);
                    end
                end
                CMD_MATCH: begin
                    r_match_node <= n_match_node;
                    r_match_mode <= n_match_mode;
                end
                CMD_CLEAR: begin
                    r_ins_node    <= '0;
                    r_ins_dropped <= 1'b0;
                    r_match_node  <= '0;
                    r_match_mode  <= MODE_SEARCH;
                    r_next_free   <= CNT_W'(1);
                end
                default: begin
                    r_next_free <= r_next_free;
                end
            endcase
        end
    end

    assign o_out_item = r_out;

    `TRPT_ASSERT_SAME(a_free_count_range, i_clk, i_rst_n,
        1'b1, (r_next_free != '0) && (r_next_free <= CNT_W'(MAX_NODES)),
        "free node count left its range")
    `TRPT_ASSERT_SAME(a_alloc_has_room, i_clk, i_rst_n,
        o_status.need_alloc, r_next_free < CNT_W'(MAX_NODES),
        "allocation requested from a full node store")
    `TRPT_ASSERT_SAME(a_alloc_walk_live, i_clk, i_rst_n,
        o_status.need_alloc, !r_ins_dropped,
        "allocation requested for a dropped root")

endmodule

`default_nettype wire

/* hw/rtl/trie_root_prefix_truncator_core.sv */
// An accepted transaction is looked up in the next state; its result is registered
// once the result slot is free. No new transaction is taken before the last is done;
// an insert that allocates a node passes the allocate state, since the parent's row
// and the new node's cleared row are written in turn. A result that is held by the
// output stall holds the block until it is taken. Reset is synchronous, active low;
// the cycle after reset zeroes the root row, and a clear command empties the trie.
`default_nettype none

module trie_root_prefix_truncator_core
    import trpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_ctl_cmd   ctl;
    t_dp_status status;

    trpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_ctl       (ctl)
    );

    trpt_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_status   (status),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
